FILE: src/x86_64_instruction_encoder_unit_macros.svh
// assertion macros for the instruction encoder
`ifndef X86_64_INSTRUCTION_ENCODER_UNIT_MACROS_SVH
`define X86_64_INSTRUCTION_ENCODER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define XIE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define XIE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define XIE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define XIE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/xie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xie_pkg
// types and constants shared by the instruction encoder
// ----------------------------------------------------------------------------
package xie_pkg;
	localparam int MaxBytes = 20;
	localparam int LenW = 5;
	localparam int IdxW = 5;

	typedef logic [7:0] byte_t;
	typedef byte_t [MaxBytes-1:0] seq_t;

	typedef struct packed {
		seq_t seq;
		logic [LenW-1:0] len;
	} enc_t;

	localparam logic [5:0] K_PROLOGUE = 6'd0;
	localparam logic [5:0] K_EPILOGUE = 6'd1;
	localparam logic [5:0] K_MOV_IMM = 6'd2;
	localparam logic [5:0] K_MOV_RR = 6'd3;
	localparam logic [5:0] K_SPILL = 6'd4;
	localparam logic [5:0] K_LOAD = 6'd5;
	localparam logic [5:0] K_ADD_RR = 6'd6;
	localparam logic [5:0] K_ADD_IMM = 6'd7;
	localparam logic [5:0] K_SUB_RR = 6'd8;
	localparam logic [5:0] K_SUB_IMM = 6'd9;
	localparam logic [5:0] K_IMUL = 6'd10;
	localparam logic [5:0] K_IDIV = 6'd11;
	localparam logic [5:0] K_INC = 6'd12;
	localparam logic [5:0] K_DEC = 6'd13;
	localparam logic [5:0] K_NEG = 6'd14;
	localparam logic [5:0] K_SHL = 6'd15;
	localparam logic [5:0] K_SHR = 6'd16;
	localparam logic [5:0] K_AND = 6'd17;
	localparam logic [5:0] K_OR = 6'd18;
	localparam logic [5:0] K_XOR = 6'd19;
	localparam logic [5:0] K_MOVSD_LD = 6'd20;
	localparam logic [5:0] K_MOVSD_ST = 6'd21;
	localparam logic [5:0] K_ADDSD = 6'd22;
	localparam logic [5:0] K_SUBSD = 6'd23;
	localparam logic [5:0] K_MULSD = 6'd24;
	localparam logic [5:0] K_DIVSD = 6'd25;
	localparam logic [5:0] K_SQRTSD = 6'd26;
	localparam logic [5:0] K_CVTSI2SD = 6'd27;
	localparam logic [5:0] K_CVTTSD2SI = 6'd28;
	localparam logic [5:0] K_CMP_RR = 6'd29;
	localparam logic [5:0] K_CMP_IMM = 6'd30;
	localparam logic [5:0] K_TEST = 6'd31;
	localparam logic [5:0] K_SETE = 6'd32;
	localparam logic [5:0] K_SETNE = 6'd33;
	localparam logic [5:0] K_SETL = 6'd34;
	localparam logic [5:0] K_SETLE = 6'd35;
	localparam logic [5:0] K_SETG = 6'd36;
	localparam logic [5:0] K_SETGE = 6'd37;
	localparam logic [5:0] K_JMP = 6'd38;
	localparam logic [5:0] K_JE = 6'd39;
	localparam logic [5:0] K_JNE = 6'd40;
	localparam logic [5:0] K_JL = 6'd41;
	localparam logic [5:0] K_JLE = 6'd42;
	localparam logic [5:0] K_JG = 6'd43;
	localparam logic [5:0] K_JGE = 6'd44;
	localparam logic [5:0] K_CALL_R = 6'd45;
	localparam logic [5:0] K_CALL_ABS = 6'd46;
	localparam logic [5:0] K_RET = 6'd47;
	localparam logic [5:0] K_NOP = 6'd48;
	localparam logic [5:0] K_SYSCALL = 6'd49;

	function automatic byte_t rexw(input logic [3:0] r, input logic [3:0] b);
		rexw = {5'b01001, r[3], 1'b0, b[3]};
	endfunction

	function automatic byte_t mrm(input logic [1:0] md, input logic [2:0] rg,
			input logic [2:0] rm);
		mrm = {md, rg, rm};
	endfunction
endpackage

FILE: src/x86_64_instruction_encoder_unit.sv
`timescale 1ns / 1ps
// an accepted request passes the input register and then the byte register before its first byte is shown
// bytes leave one per cycle while out_stall is low; a request encodes to at most 20 bytes
// the next request is registered in the cycle the last byte of the current one leaves
// requests that encode to no bytes pass with no output
// reset (arst_n low) empties the input and byte registers at once
// ----------------------------------------------------------------------------
// x86_64_instruction_encoder_unit
// encodes one instruction request into x86-64 machine code bytes
// ----------------------------------------------------------------------------
module x86_64_instruction_encoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [5:0]  kind,
	input  logic [3:0]  first_reg,
	input  logic [3:0]  second_reg,
	input  logic [63:0] operand_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  code_byte,
	output logic        last_byte
);
	logic v_s1;
	logic [5:0] kind_s1;
	logic [3:0] a_s1;
	logic [3:0] b_s1;
	logic [63:0] val_s1;
	xie_pkg::enc_t enc;
	logic busy;
	logic load;

	// input register drains into the byte register when it is free
	assign load = v_s1 && !busy;
	assign in_stall = v_s1 && busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			a_s1 <= first_reg;
			b_s1 <= second_reg;
			val_s1 <= operand_value;
		end
	end

	xie_encode u_enc (
		.kind(kind_s1),
		.first_reg(a_s1),
		.second_reg(b_s1),
		.operand_value(val_s1),
		.enc(enc)
	);

	xie_serializer u_ser (
		.clk(clk),
		.arst_n(arst_n),
		.load(load),
		.enc(enc),
		.busy(busy),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.code_byte(code_byte),
		.last_byte(last_byte)
	);
endmodule

FILE: src/xie_encode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xie_encode
// combinational byte-sequence builder for one instruction request
// ----------------------------------------------------------------------------
module xie_encode (
	input  logic [5:0]  kind,
	input  logic [3:0]  first_reg,
	input  logic [3:0]  second_reg,
	input  logic [63:0] operand_value,
	output xie_pkg::enc_t enc
);
	logic [31:0] lo;
	logic [31:0] disp;
	logic [31:0] aligned;
	xie_pkg::seq_t s;
	logic [xie_pkg::LenW-1:0] n;
	logic [3:0] a;
	logic [3:0] b;

	assign lo = operand_value[31:0];
	assign disp = 32'd0 - lo;
	assign aligned = (lo + 32'd15) & 32'hFFFF_FFF0;
	assign a = first_reg;
	assign b = second_reg;

	always_comb begin
		s = '0;
		n = '0;
		case (kind)
			xie_pkg::K_PROLOGUE: begin
				s[0] = 8'h55; s[1] = 8'h48; s[2] = 8'h89; s[3] = 8'hE5;
				s[4] = 8'h53; s[5] = 8'h41; s[6] = 8'h54; s[7] = 8'h41;
				s[8] = 8'h55; s[9] = 8'h41; s[10] = 8'h56; s[11] = 8'h41;
				s[12] = 8'h57;
				n = 5'd13;
				if (aligned != 32'd0 && !aligned[31]) begin
					s[13] = 8'h48; s[14] = 8'h81; s[15] = 8'hEC;
					s[16] = aligned[7:0]; s[17] = aligned[15:8];
					s[18] = aligned[23:16]; s[19] = aligned[31:24];
					n = 5'd20;
				end
			end
			xie_pkg::K_EPILOGUE: begin
				s[0] = 8'h41; s[1] = 8'h5F; s[2] = 8'h41; s[3] = 8'h5E;
				s[4] = 8'h41; s[5] = 8'h5D; s[6] = 8'h41; s[7] = 8'h5C;
				s[8] = 8'h5B; s[9] = 8'h48; s[10] = 8'h89; s[11] = 8'hEC;
				s[12] = 8'h5D; s[13] = 8'hC3;
				n = 5'd14;
			end
			xie_pkg::K_MOV_IMM: begin
				s[0] = xie_pkg::rexw(4'd0, a);
				s[1] = 8'hB8 | {5'd0, a[2:0]};
				for (int i = 0; i < 8; i++) s[2+i] = operand_value[8*i +: 8];
				n = 5'd10;
			end
			xie_pkg::K_MOV_RR, xie_pkg::K_ADD_RR, xie_pkg::K_SUB_RR, xie_pkg::K_AND,
			xie_pkg::K_OR, xie_pkg::K_CMP_RR, xie_pkg::K_TEST: begin
				s[0] = xie_pkg::rexw(b, a);
				case (kind)
					xie_pkg::K_MOV_RR: s[1] = 8'h89;
					xie_pkg::K_ADD_RR: s[1] = 8'h01;
					xie_pkg::K_SUB_RR: s[1] = 8'h29;
					xie_pkg::K_AND:    s[1] = 8'h21;
					xie_pkg::K_OR:     s[1] = 8'h09;
					xie_pkg::K_CMP_RR: s[1] = 8'h39;
					default:           s[1] = 8'h85;
				endcase
				s[2] = xie_pkg::mrm(2'd3, b[2:0], a[2:0]);
				n = 5'd3;
			end
			xie_pkg::K_XOR: begin
				s[0] = xie_pkg::rexw(a, b); s[1] = 8'h33;
				s[2] = xie_pkg::mrm(2'd3, a[2:0], b[2:0]);
				n = 5'd3;
			end
			xie_pkg::K_SPILL, xie_pkg::K_LOAD: begin
				s[0] = xie_pkg::rexw(a, 4'd0);
				s[1] = (kind == xie_pkg::K_SPILL) ? 8'h89 : 8'h8B;
				s[2] = xie_pkg::mrm(2'd2, a[2:0], 3'd5);
				s[3] = disp[7:0]; s[4] = disp[15:8];
				s[5] = disp[23:16]; s[6] = disp[31:24];
				n = 5'd7;
			end
			xie_pkg::K_ADD_IMM, xie_pkg::K_SUB_IMM, xie_pkg::K_CMP_IMM: begin
				s[0] = xie_pkg::rexw(4'd0, a); s[1] = 8'h81;
				case (kind)
					xie_pkg::K_ADD_IMM: s[2] = xie_pkg::mrm(2'd3, 3'd0, a[2:0]);
					xie_pkg::K_SUB_IMM: s[2] = xie_pkg::mrm(2'd3, 3'd5, a[2:0]);
					default:            s[2] = xie_pkg::mrm(2'd3, 3'd7, a[2:0]);
				endcase
				s[3] = lo[7:0]; s[4] = lo[15:8]; s[5] = lo[23:16]; s[6] = lo[31:24];
				n = 5'd7;
			end
			xie_pkg::K_IMUL: begin
				s[0] = xie_pkg::rexw(a, b); s[1] = 8'h0F; s[2] = 8'hAF;
				s[3] = xie_pkg::mrm(2'd3, a[2:0], b[2:0]);
				n = 5'd4;
			end
			xie_pkg::K_IDIV: begin
				s[0] = 8'h48; s[1] = 8'h99; s[2] = 8'h48; s[3] = 8'hF7; s[4] = 8'hF9;
				n = 5'd5;
			end
			xie_pkg::K_INC, xie_pkg::K_DEC, xie_pkg::K_NEG: begin
				s[0] = xie_pkg::rexw(4'd0, a);
				s[1] = (kind == xie_pkg::K_NEG) ? 8'hF7 : 8'hFF;
				case (kind)
					xie_pkg::K_INC: s[2] = xie_pkg::mrm(2'd3, 3'd0, a[2:0]);
					xie_pkg::K_DEC: s[2] = xie_pkg::mrm(2'd3, 3'd1, a[2:0]);
					default:        s[2] = xie_pkg::mrm(2'd3, 3'd3, a[2:0]);
				endcase
				n = 5'd3;
			end
			xie_pkg::K_SHL, xie_pkg::K_SHR: begin
				s[0] = xie_pkg::rexw(4'd0, a); s[1] = 8'hC1;
				s[2] = xie_pkg::mrm(2'd3, (kind == xie_pkg::K_SHL) ? 3'd4 : 3'd5, a[2:0]);
				s[3] = lo[7:0];
				n = 5'd4;
			end
			xie_pkg::K_MOVSD_LD, xie_pkg::K_MOVSD_ST: begin
				s[0] = 8'hF2; s[1] = 8'h0F;
				s[2] = (kind == xie_pkg::K_MOVSD_LD) ? 8'h10 : 8'h11;
				s[3] = xie_pkg::mrm(2'd2, a[2:0], 3'd5);
				s[4] = disp[7:0]; s[5] = disp[15:8];
				s[6] = disp[23:16]; s[7] = disp[31:24];
				n = 5'd8;
			end
			xie_pkg::K_ADDSD, xie_pkg::K_SUBSD, xie_pkg::K_MULSD, xie_pkg::K_DIVSD,
			xie_pkg::K_SQRTSD: begin
				s[0] = 8'hF2; s[1] = 8'h0F;
				case (kind)
					xie_pkg::K_ADDSD: s[2] = 8'h58;
					xie_pkg::K_SUBSD: s[2] = 8'h5C;
					xie_pkg::K_MULSD: s[2] = 8'h59;
					xie_pkg::K_DIVSD: s[2] = 8'h5E;
					default:          s[2] = 8'h51;
				endcase
				s[3] = xie_pkg::mrm(2'd3, a[2:0], b[2:0]);
				n = 5'd4;
			end
			xie_pkg::K_CVTSI2SD, xie_pkg::K_CVTTSD2SI: begin
				s[0] = 8'hF2; s[1] = xie_pkg::rexw(a, b); s[2] = 8'h0F;
				s[3] = (kind == xie_pkg::K_CVTSI2SD) ? 8'h2A : 8'h2C;
				s[4] = xie_pkg::mrm(2'd3, a[2:0], b[2:0]);
				n = 5'd5;
			end
			xie_pkg::K_SETE, xie_pkg::K_SETNE, xie_pkg::K_SETL, xie_pkg::K_SETLE,
			xie_pkg::K_SETG, xie_pkg::K_SETGE: begin
				s[0] = 8'h0F;
				case (kind)
					xie_pkg::K_SETE:  s[1] = 8'h94;
					xie_pkg::K_SETNE: s[1] = 8'h95;
					xie_pkg::K_SETL:  s[1] = 8'h9C;
					xie_pkg::K_SETLE: s[1] = 8'h9E;
					xie_pkg::K_SETG:  s[1] = 8'h9F;
					default:          s[1] = 8'h9D;
				endcase
				s[2] = 8'hC0;
				n = 5'd3;
			end
			xie_pkg::K_JMP: begin
				s[0] = 8'hE9;
				s[1] = lo[7:0]; s[2] = lo[15:8]; s[3] = lo[23:16]; s[4] = lo[31:24];
				n = 5'd5;
			end
			xie_pkg::K_JE, xie_pkg::K_JNE, xie_pkg::K_JL, xie_pkg::K_JLE,
			xie_pkg::K_JG, xie_pkg::K_JGE: begin
				s[0] = 8'h0F;
				case (kind)
					xie_pkg::K_JE:  s[1] = 8'h84;
					xie_pkg::K_JNE: s[1] = 8'h85;
					xie_pkg::K_JL:  s[1] = 8'h8C;
					xie_pkg::K_JLE: s[1] = 8'h8E;
					xie_pkg::K_JG:  s[1] = 8'h8F;
					default:        s[1] = 8'h8D;
				endcase
				s[2] = lo[7:0]; s[3] = lo[15:8]; s[4] = lo[23:16]; s[5] = lo[31:24];
				n = 5'd6;
			end
			xie_pkg::K_CALL_R: begin
				if (a[3]) begin
					s[0] = 8'h41; s[1] = 8'hFF;
					s[2] = xie_pkg::mrm(2'd3, 3'd2, a[2:0]);
					n = 5'd3;
				end else begin
					s[0] = 8'hFF; s[1] = xie_pkg::mrm(2'd3, 3'd2, a[2:0]);
					n = 5'd2;
				end
			end
			xie_pkg::K_CALL_ABS: begin
				s[0] = 8'h49; s[1] = 8'hBB;
				for (int i = 0; i < 8; i++) s[2+i] = operand_value[8*i +: 8];
				s[10] = 8'h41; s[11] = 8'hFF; s[12] = 8'hD3;
				n = 5'd13;
			end
			xie_pkg::K_RET: begin s[0] = 8'hC3; n = 5'd1; end
			xie_pkg::K_NOP: begin s[0] = 8'h90; n = 5'd1; end
			xie_pkg::K_SYSCALL: begin s[0] = 8'h0F; s[1] = 8'h05; n = 5'd2; end
			default: begin
				n = '0;
			end
		endcase
	end

	assign enc.seq = s;
	assign enc.len = n;
endmodule

FILE: src/xie_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xie_serializer
// holds one encoded sequence and emits it a byte per cycle while out_stall is low
// ----------------------------------------------------------------------------
`include "x86_64_instruction_encoder_unit_macros.svh"
module xie_serializer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  xie_pkg::enc_t enc,
	output logic          busy,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    code_byte,
	output logic          last_byte
);
	xie_pkg::seq_t seq_q;
	logic [xie_pkg::LenW-1:0] len_q;
	logic [xie_pkg::IdxW-1:0] idx_q;
	logic fin;

	assign out_valid = (len_q != '0);
	assign code_byte = seq_q[idx_q];
	assign last_byte = (idx_q == len_q - 5'd1);
	assign fin = out_valid && !out_stall && last_byte;
	// free when empty or handing over the last byte this cycle
	assign busy = out_valid && !fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			len_q <= enc.len;
			idx_q <= '0;
		end else if (fin) begin
			len_q <= '0;
			idx_q <= '0;
		end else if (out_valid && !out_stall) begin
			idx_q <= idx_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) seq_q <= enc.seq;
	end

	`XIE_ASSERT_IMP(a_idx_in_range, clk, arst_n, out_valid, idx_q < len_q)
	`XIE_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(idx_q))
	`XIE_ASSERT_IMP(a_load_when_free, clk, arst_n, load, !busy)
endmodule

FILE: tb/x86_64_instruction_encoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_64_instruction_encoder_checker
// watches both channels of the encoder, predicts the machine code bytes of
// every accepted request and compares them in order with the emitted bytes
// ----------------------------------------------------------------------------
module x86_64_instruction_encoder_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [5:0]  kind,
	input  logic [3:0]  first_reg,
	input  logic [3:0]  second_reg,
	input  logic [63:0] operand_value,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  code_byte,
	input  logic        last_byte,
	output int          fail_count,
	output int          pending_bytes,
	output int          bytes_seen
);
	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} code_item_t;

	code_item_t expected_code[$];
	xie_pkg::byte_t enc_buf[$];

	function automatic xie_pkg::byte_t rex_of(input logic [3:0] r, input logic [3:0] b);
		return {4'h4, 1'b1, r[3], 1'b0, b[3]};
	endfunction

	function automatic xie_pkg::byte_t modrm_of(input logic [1:0] md, input logic [3:0] rg,
			input logic [3:0] rm);
		return {md, rg[2:0], rm[2:0]};
	endfunction

	task automatic emit32(input logic [31:0] v);
		for (int i = 0; i < 4; i++) enc_buf.push_back(v[8*i +: 8]);
	endtask

	task automatic emit64(input logic [63:0] v);
		for (int i = 0; i < 8; i++) enc_buf.push_back(v[8*i +: 8]);
	endtask

	task automatic rr_form(input xie_pkg::byte_t op, input logic [3:0] rm,
			input logic [3:0] rg);
		enc_buf.push_back(rex_of(rg, rm));
		enc_buf.push_back(op);
		enc_buf.push_back(modrm_of(2'd3, rg, rm));
	endtask

	task automatic rbp_form(input xie_pkg::byte_t op, input logic [3:0] r,
			input logic [31:0] lo, input logic sse);
		if (sse) begin
			enc_buf.push_back(8'hF2);
			enc_buf.push_back(8'h0F);
		end else begin
			enc_buf.push_back(rex_of(r, 4'd0));
		end
		enc_buf.push_back(op);
		enc_buf.push_back(modrm_of(2'd2, r, 4'd5));
		emit32(32'd0 - lo);
	endtask

	task automatic sse_pair(input xie_pkg::byte_t op, input logic [3:0] d,
			input logic [3:0] s);
		enc_buf.push_back(8'hF2);
		enc_buf.push_back(8'h0F);
		enc_buf.push_back(op);
		enc_buf.push_back(modrm_of(2'd3, d, s));
	endtask

	task automatic sse_convert(input xie_pkg::byte_t op, input logic [3:0] d,
			input logic [3:0] s);
		enc_buf.push_back(8'hF2);
		enc_buf.push_back(rex_of(d, s));
		enc_buf.push_back(8'h0F);
		enc_buf.push_back(op);
		enc_buf.push_back(modrm_of(2'd3, d, s));
	endtask

	task automatic encode_request(input logic [5:0] k, input logic [3:0] a,
			input logic [3:0] b, input logic [63:0] v);
		logic [31:0] lo;
		logic [31:0] frame;
		xie_pkg::byte_t set_ops[6];
		xie_pkg::byte_t jcc_ops[6];
		xie_pkg::byte_t pro[13];
		xie_pkg::byte_t epi[14];
		lo = v[31:0];
		set_ops = '{8'h94, 8'h95, 8'h9C, 8'h9E, 8'h9F, 8'h9D};
		jcc_ops = '{8'h84, 8'h85, 8'h8C, 8'h8E, 8'h8F, 8'h8D};
		pro = '{8'h55, 8'h48, 8'h89, 8'hE5, 8'h53, 8'h41, 8'h54, 8'h41, 8'h55,
			8'h41, 8'h56, 8'h41, 8'h57};
		epi = '{8'h41, 8'h5F, 8'h41, 8'h5E, 8'h41, 8'h5D, 8'h41, 8'h5C, 8'h5B,
			8'h48, 8'h89, 8'hEC, 8'h5D, 8'hC3};
		enc_buf.delete();
		case (k)
			xie_pkg::K_PROLOGUE: begin
				foreach (pro[i]) enc_buf.push_back(pro[i]);
				frame = (lo + 32'd15) & 32'hFFFF_FFF0;
				if (frame != 0 && !frame[31]) begin
					enc_buf.push_back(8'h48);
					enc_buf.push_back(8'h81);
					enc_buf.push_back(8'hEC);
					emit32(frame);
				end
			end
			xie_pkg::K_EPILOGUE: foreach (epi[i]) enc_buf.push_back(epi[i]);
			xie_pkg::K_MOV_IMM: begin
				enc_buf.push_back(rex_of(4'd0, a));
				enc_buf.push_back(8'hB8 | {5'd0, a[2:0]});
				emit64(v);
			end
			xie_pkg::K_MOV_RR:  rr_form(8'h89, a, b);
			xie_pkg::K_SPILL:   rbp_form(8'h89, a, lo, 1'b0);
			xie_pkg::K_LOAD:    rbp_form(8'h8B, a, lo, 1'b0);
			xie_pkg::K_ADD_RR:  rr_form(8'h01, a, b);
			xie_pkg::K_ADD_IMM: begin rr_form(8'h81, a, 4'd0); emit32(lo); end
			xie_pkg::K_SUB_RR:  rr_form(8'h29, a, b);
			xie_pkg::K_SUB_IMM: begin rr_form(8'h81, a, 4'd5); emit32(lo); end
			xie_pkg::K_IMUL: begin
				enc_buf.push_back(rex_of(a, b));
				enc_buf.push_back(8'h0F);
				enc_buf.push_back(8'hAF);
				enc_buf.push_back(modrm_of(2'd3, a, b));
			end
			xie_pkg::K_IDIV: begin
				enc_buf.push_back(8'h48);
				enc_buf.push_back(8'h99);
				enc_buf.push_back(8'h48);
				enc_buf.push_back(8'hF7);
				enc_buf.push_back(8'hF9);
			end
			xie_pkg::K_INC: rr_form(8'hFF, a, 4'd0);
			xie_pkg::K_DEC: rr_form(8'hFF, a, 4'd1);
			xie_pkg::K_NEG: rr_form(8'hF7, a, 4'd3);
			xie_pkg::K_SHL: begin rr_form(8'hC1, a, 4'd4); enc_buf.push_back(lo[7:0]); end
			xie_pkg::K_SHR: begin rr_form(8'hC1, a, 4'd5); enc_buf.push_back(lo[7:0]); end
			xie_pkg::K_AND: rr_form(8'h21, a, b);
			xie_pkg::K_OR:  rr_form(8'h09, a, b);
			// xor uses the load direction: dst in reg field
			xie_pkg::K_XOR: rr_form(8'h33, b, a);
			xie_pkg::K_MOVSD_LD:  rbp_form(8'h10, a, lo, 1'b1);
			xie_pkg::K_MOVSD_ST:  rbp_form(8'h11, a, lo, 1'b1);
			xie_pkg::K_ADDSD:     sse_pair(8'h58, a, b);
			xie_pkg::K_SUBSD:     sse_pair(8'h5C, a, b);
			xie_pkg::K_MULSD:     sse_pair(8'h59, a, b);
			xie_pkg::K_DIVSD:     sse_pair(8'h5E, a, b);
			xie_pkg::K_SQRTSD:    sse_pair(8'h51, a, b);
			xie_pkg::K_CVTSI2SD:  sse_convert(8'h2A, a, b);
			xie_pkg::K_CVTTSD2SI: sse_convert(8'h2C, a, b);
			xie_pkg::K_CMP_RR:    rr_form(8'h39, a, b);
			xie_pkg::K_CMP_IMM: begin rr_form(8'h81, a, 4'd7); emit32(lo); end
			xie_pkg::K_TEST:      rr_form(8'h85, a, b);
			xie_pkg::K_SETE, xie_pkg::K_SETNE, xie_pkg::K_SETL, xie_pkg::K_SETLE,
			xie_pkg::K_SETG, xie_pkg::K_SETGE: begin
				enc_buf.push_back(8'h0F);
				enc_buf.push_back(set_ops[k - xie_pkg::K_SETE]);
				enc_buf.push_back(8'hC0);
			end
			xie_pkg::K_JMP: begin enc_buf.push_back(8'hE9); emit32(lo); end
			xie_pkg::K_JE, xie_pkg::K_JNE, xie_pkg::K_JL, xie_pkg::K_JLE,
			xie_pkg::K_JG, xie_pkg::K_JGE: begin
				enc_buf.push_back(8'h0F);
				enc_buf.push_back(jcc_ops[k - xie_pkg::K_JE]);
				emit32(lo);
			end
			xie_pkg::K_CALL_R: begin
				if (a[3]) enc_buf.push_back(8'h41);
				enc_buf.push_back(8'hFF);
				enc_buf.push_back(modrm_of(2'd3, 4'd2, a));
			end
			xie_pkg::K_CALL_ABS: begin
				enc_buf.push_back(8'h49);
				enc_buf.push_back(8'hBB);
				emit64(v);
				enc_buf.push_back(8'h41);
				enc_buf.push_back(8'hFF);
				enc_buf.push_back(8'hD3);
			end
			xie_pkg::K_RET:     enc_buf.push_back(8'hC3);
			xie_pkg::K_NOP:     enc_buf.push_back(8'h90);
			xie_pkg::K_SYSCALL: begin enc_buf.push_back(8'h0F); enc_buf.push_back(8'h05); end
			default: ;
		endcase
		foreach (enc_buf[i])
			expected_code.push_back('{code: enc_buf[i], last: (i == enc_buf.size() - 1)});
	endtask

	task automatic report_mismatch(input string what);
		fail_count++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	initial begin
		fail_count = 0;
		bytes_seen = 0;
		pending_bytes = 0;
	end

	always @(posedge clk) begin
		code_item_t exp_item;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				bytes_seen++;
				if (expected_code.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %h", code_byte));
				end else begin
					exp_item = expected_code.pop_front();
					if (code_byte !== exp_item.code)
						report_mismatch($sformatf("code_byte %h, want %h",
							code_byte, exp_item.code));
					if (last_byte !== exp_item.last)
						report_mismatch($sformatf("last_byte %b, want %b on byte %h",
							last_byte, exp_item.last, exp_item.code));
				end
			end
			if (in_valid && !in_stall)
				encode_request(kind, first_reg, second_reg, operand_value);
		end
		pending_bytes = expected_code.size();
	end
endmodule

FILE: tb/tb_x86_64_instruction_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_x86_64_instruction_encoder_unit
// drives directed and random instruction requests with random gaps and
// output stalls; a checker beside the encoder predicts and compares bytes
// ----------------------------------------------------------------------------
module tb_x86_64_instruction_encoder_unit;
	localparam int NumRandom = 176;
	localparam int CycleLimit = 1000000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [5:0]  kind;
	logic [3:0]  first_reg;
	logic [3:0]  second_reg;
	logic [63:0] operand_value;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  code_byte;
	logic        last_byte;
	int          fail_count;
	int          pending_bytes;
	int          bytes_seen;
	int          cycle_count;
	int          requests_sent;
	logic        stall_enable;

	x86_64_instruction_encoder_unit dut (.*);

	x86_64_instruction_encoder_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CycleLimit) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("FAIL x86_64_instruction_encoder_unit");
				$finish;
			end
		end
	end

	// output stall: a random hold before each byte, with a quiet stretch mid run
	initial begin
		int hold;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_enable && out_valid) begin
				hold = $urandom_range(0, 19);
				if (hold != 0) begin
					out_stall <= 1'b1;
					repeat (hold) @(negedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	task automatic send_request(input logic [5:0] k, input logic [3:0] a,
			input logic [3:0] b, input logic [63:0] v, input int gap);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		kind <= k;
		first_reg <= a;
		second_reg <= b;
		operand_value <= v;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		requests_sent++;
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand_value();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: v = {{32{v[31]}}, v[31:0]};
			1: v = 64'($urandom_range(0, 300));
			2: v = 64'd0 - 64'($urandom_range(0, 300));
			3: v = {1'b0, {63{1'b1}}};
			default: ;
		endcase
		return v;
	endfunction

	initial begin
		logic [5:0] k;
		requests_sent = 0;
		stall_enable = 1'b0;
		in_valid = 1'b0;
		kind = '0;
		first_reg = '0;
		second_reg = '0;
		operand_value = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: frame sizes around the rounding and sign edges, then register, operand and unused-kind edges
		send_request(xie_pkg::K_PROLOGUE, 4'd0, 4'd0, 64'd0, 0);
		send_request(xie_pkg::K_PROLOGUE, 4'd0, 4'd0, 64'd1, 0);
		send_request(xie_pkg::K_PROLOGUE, 4'd0, 4'd0, 64'h0000_0000_7FFF_FFF0, 0);
		send_request(xie_pkg::K_PROLOGUE, 4'd0, 4'd0, 64'hFFFF_FFFF_FFFF_FFF8, 1);
		send_request(xie_pkg::K_PROLOGUE, 4'd0, 4'd0, 64'h0000_0000_7FFF_FFF1, 0);
		send_request(xie_pkg::K_EPILOGUE, 4'd0, 4'd0, 64'd0, 0);
		send_request(xie_pkg::K_MOV_IMM, 4'd15, 4'd0, 64'h8000_0000_0000_0000, 0);
		send_request(xie_pkg::K_MOV_IMM, 4'd7, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 0);
		send_request(xie_pkg::K_MOV_RR, 4'd15, 4'd0, 64'd0, 2);
		send_request(xie_pkg::K_MOV_RR, 4'd0, 4'd15, 64'd0, 0);
		send_request(xie_pkg::K_SPILL, 4'd12, 4'd0, 64'h8000_0000, 0);
		send_request(xie_pkg::K_LOAD, 4'd3, 4'd0, 64'd0, 0);
		send_request(xie_pkg::K_XOR, 4'd9, 4'd2, 64'd0, 0);
		send_request(xie_pkg::K_SHL, 4'd8, 4'd0, 64'h1FF, 0);
		send_request(xie_pkg::K_CVTSI2SD, 4'd15, 4'd8, 64'd0, 0);
		send_request(xie_pkg::K_CVTTSD2SI, 4'd3, 4'd12, 64'd0, 0);
		send_request(xie_pkg::K_ADDSD, 4'd15, 4'd9, 64'd0, 0);
		send_request(xie_pkg::K_CALL_R, 4'd11, 4'd0, 64'd0, 0);
		send_request(xie_pkg::K_CALL_R, 4'd2, 4'd0, 64'd0, 0);
		send_request(xie_pkg::K_CALL_ABS, 4'd0, 4'd0, 64'h0123_4567_89AB_CDEF, 0);
		send_request(6'd50, 4'd0, 4'd0, 64'd0, 0);
		send_request(6'd63, 4'd5, 4'd5, 64'd5, 0);
		send_request(xie_pkg::K_RET, 4'd0, 4'd0, 64'd0, 0);
		send_request(xie_pkg::K_SYSCALL, 4'd0, 4'd0, 64'd0, 0);
		// every kind once, ahead of the random part
		for (int i = 0; i <= xie_pkg::K_SYSCALL; i++)
			send_request(i[5:0], 4'($urandom), 4'($urandom), rand_value(), 0);

		stall_enable = 1'b1;
		for (int i = 0; i < NumRandom; i++) begin
			if (i == NumRandom / 2) stall_enable = 1'b0;
			if (i == NumRandom * 3 / 4) stall_enable = 1'b1;
			k = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(50, 63))
				: 6'($urandom_range(0, 49));
			send_request(k, 4'($urandom), 4'($urandom), rand_value(),
				(i >= NumRandom / 2 && i < NumRandom * 3 / 4) ? 0 : $urandom_range(0, 19));
		end
		in_valid <= 1'b0;

		while (pending_bytes != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		$display("sent %0d requests covering all kinds, checked %0d bytes",
			requests_sent, bytes_seen);
		if (fail_count == 0) begin
			$display("PASS x86_64_instruction_encoder_unit");
		end else begin
			$display("FAIL x86_64_instruction_encoder_unit");
		end
		$finish;
	end
endmodule

FILE: files.f
+incdir+src
src/xie_pkg.sv
src/xie_encode.sv
src/xie_serializer.sv
src/x86_64_instruction_encoder_unit.sv
tb/x86_64_instruction_encoder_checker.sv
tb/tb_x86_64_instruction_encoder_unit.sv
